// ===== sv/bk128_pkg.sv =====
// Shared types, constants and the S-box helper function of the 128-bit block cipher pipeline.
`timescale 1ns / 1ps

package bk128_pkg;

  localparam int MAX_ROUNDS = 35;
  localparam int BLOCK_W = 128;
  localparam int HALF_W = 64;
  localparam int ROUND_W = 6;
  localparam int NUM_RC_BITS = 6;

  typedef enum logic [1:0] {
    REG_KEY_LOW  = 2'd0,
    REG_KEY_HIGH = 2'd1,
    REG_ROUNDS   = 2'd2,
    REG_USE_RC   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                 valid;
    logic [ROUND_W-1:0]   left;
    logic [BLOCK_W-1:0]   key;
    logic [BLOCK_W-1:0]   state;
  } cell_t;

  localparam logic [3:0] SBOX [16] = '{
    4'h3, 4'h0, 4'h6, 4'hD, 4'hB, 4'h5, 4'h8, 4'hE,
    4'hC, 4'hF, 4'h9, 4'h2, 4'h4, 4'hA, 4'h7, 4'h1
  };

  localparam logic [6:0] PERM [BLOCK_W] = '{
    7'd0,   7'd33,  7'd66,  7'd99,  7'd96,  7'd1,   7'd34,  7'd67,
    7'd64,  7'd97,  7'd2,   7'd35,  7'd32,  7'd65,  7'd98,  7'd3,
    7'd4,   7'd37,  7'd70,  7'd103, 7'd100, 7'd5,   7'd38,  7'd71,
    7'd68,  7'd101, 7'd6,   7'd39,  7'd36,  7'd69,  7'd102, 7'd7,
    7'd8,   7'd41,  7'd74,  7'd107, 7'd104, 7'd9,   7'd42,  7'd75,
    7'd72,  7'd105, 7'd10,  7'd43,  7'd40,  7'd73,  7'd106, 7'd11,
    7'd12,  7'd45,  7'd78,  7'd111, 7'd108, 7'd13,  7'd46,  7'd79,
    7'd76,  7'd109, 7'd14,  7'd47,  7'd44,  7'd77,  7'd110, 7'd15,
    7'd16,  7'd49,  7'd82,  7'd115, 7'd112, 7'd17,  7'd50,  7'd83,
    7'd80,  7'd113, 7'd18,  7'd51,  7'd48,  7'd81,  7'd114, 7'd19,
    7'd20,  7'd53,  7'd86,  7'd119, 7'd116, 7'd21,  7'd54,  7'd87,
    7'd84,  7'd117, 7'd22,  7'd55,  7'd52,  7'd85,  7'd118, 7'd23,
    7'd24,  7'd57,  7'd90,  7'd123, 7'd120, 7'd25,  7'd58,  7'd91,
    7'd88,  7'd121, 7'd26,  7'd59,  7'd56,  7'd89,  7'd122, 7'd27,
    7'd28,  7'd61,  7'd94,  7'd127, 7'd124, 7'd29,  7'd62,  7'd95,
    7'd92,  7'd125, 7'd30,  7'd63,  7'd60,  7'd93,  7'd126, 7'd31
  };

  localparam logic [5:0] RCON [MAX_ROUNDS] = '{
    6'd2,  6'd33, 6'd16, 6'd9,  6'd36, 6'd19, 6'd40, 6'd53, 6'd26,
    6'd13, 6'd38, 6'd51, 6'd56, 6'd61, 6'd62, 6'd31, 6'd14, 6'd7,
    6'd34, 6'd49, 6'd24, 6'd45, 6'd54, 6'd59, 6'd28, 6'd47, 6'd22,
    6'd43, 6'd20, 6'd11, 6'd4,  6'd3,  6'd32, 6'd17, 6'd8
  };

  localparam logic [6:0] RC_POS [NUM_RC_BITS] = '{
    7'd8, 7'd13, 7'd19, 7'd35, 7'd67, 7'd106
  };

  function automatic logic [3:0] sbox(input logic [3:0] nib);
    return SBOX[nib];
  endfunction

endpackage

// ===== sv/lightweight_128bit_block_encrypt.sv =====
// Top level of the 128-bit lightweight block cipher: configuration registers and round cell chain.
`timescale 1ns / 1ps

// The block accepts one item in every clock cycle and busy is always low. Each item runs
// through a chain of 35 round cells, one round per cell, so its ciphertext appears on the
// out_ ports once it has passed the register of every cell, marked by out_valid for one
// cycle. Items that need fewer rounds pass through the remaining cells unchanged, and
// results leave in the order the items entered. The receiver cannot stall the output.
// Configuration writes take effect at once and must only be made while no item is in the
// chain; a round_count above 35 is treated as 35.
module lightweight_128bit_block_encrypt (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [bk128_pkg::HALF_W-1:0]      in_plaintext_low,
  input  logic [bk128_pkg::HALF_W-1:0]      in_plaintext_high,
  output logic                              out_valid,
  output logic [bk128_pkg::HALF_W-1:0]      out_ciphertext_low,
  output logic [bk128_pkg::HALF_W-1:0]      out_ciphertext_high,
  input  logic                              cfg_we,
  input  bk128_pkg::cfg_reg_t               cfg_idx,
  input  logic [bk128_pkg::HALF_W-1:0]      cfg_data
);

  logic [bk128_pkg::HALF_W-1:0]  key_low_r;
  logic [bk128_pkg::HALF_W-1:0]  key_high_r;
  logic [bk128_pkg::ROUND_W-1:0] round_count_r;
  logic                          use_rc_r;
  logic [bk128_pkg::ROUND_W-1:0] rounds_sat;
  logic [bk128_pkg::BLOCK_W-1:0] master_key;

  bk128_pkg::cell_t chain [bk128_pkg::MAX_ROUNDS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r <= '1;
      key_high_r <= '1;
      round_count_r <= bk128_pkg::ROUND_W'(9);
      use_rc_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        bk128_pkg::REG_KEY_LOW:  key_low_r <= cfg_data;
        bk128_pkg::REG_KEY_HIGH: key_high_r <= cfg_data;
        bk128_pkg::REG_ROUNDS:   round_count_r <= cfg_data[bk128_pkg::ROUND_W-1:0];
        bk128_pkg::REG_USE_RC:   use_rc_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;
  assign master_key = {key_high_r, key_low_r};
  assign rounds_sat = (round_count_r > bk128_pkg::ROUND_W'(bk128_pkg::MAX_ROUNDS))
                    ? bk128_pkg::ROUND_W'(bk128_pkg::MAX_ROUNDS) : round_count_r;

  always_comb begin
    chain[0].valid = start & ~busy;
    chain[0].left = rounds_sat;
    chain[0].key = master_key;
    chain[0].state = {in_plaintext_high, in_plaintext_low} ^ master_key;
  end

  for (genvar k = 0; k < bk128_pkg::MAX_ROUNDS; k++) begin : g_cell
    bk128_round_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .round_idx (bk128_pkg::ROUND_W'(k)),
      .use_rc    (use_rc_r),
      .d_in      (chain[k]),
      .d_out     (chain[k+1])
    );
  end

  assign out_valid = chain[bk128_pkg::MAX_ROUNDS].valid;
  assign out_ciphertext_low = chain[bk128_pkg::MAX_ROUNDS].state[bk128_pkg::HALF_W-1:0];
  assign out_ciphertext_high =
    chain[bk128_pkg::MAX_ROUNDS].state[bk128_pkg::BLOCK_W-1:bk128_pkg::HALF_W];

  // Every item leaving the chain has used up all of its rounds.
  a_rounds_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> chain[bk128_pkg::MAX_ROUNDS].left == '0)
    else $error("item left the chain with rounds still pending");

  // An accepted item is in the first cell in the next cycle.
  a_first_cell: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> chain[1].valid)
    else $error("accepted item missing from first cell");

  // A result always comes from an item that was in the cell before the last.
  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(chain[bk128_pkg::MAX_ROUNDS-1].valid))
    else $error("result without a preceding item");

  // Reset empties the chain.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !chain[1].valid)
    else $error("chain not empty after reset");

endmodule

// ===== sv/bk128_round_cell.sv =====
// One round cell: S-box layer, bit permutation, key schedule step and round key add while rounds are left.
`timescale 1ns / 1ps

module bk128_round_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [bk128_pkg::ROUND_W-1:0]       round_idx,
  input  logic                                use_rc,
  input  bk128_pkg::cell_t                    d_in,
  output bk128_pkg::cell_t                    d_out
);

  bk128_pkg::cell_t cell_r;
  bk128_pkg::cell_t cell_nxt;

  always_comb begin
    logic [bk128_pkg::BLOCK_W-1:0] sub;
    logic [bk128_pkg::BLOCK_W-1:0] perm;
    logic [bk128_pkg::BLOCK_W-1:0] rkey;
    logic [bk128_pkg::BLOCK_W-1:0] rk;
    logic [5:0]                    rcon;
    sub = '0;
    perm = '0;
    for (int i = 0; i < bk128_pkg::BLOCK_W / 4; i++) begin
      sub[4*i +: 4] = bk128_pkg::sbox(d_in.state[4*i +: 4]);
    end
    for (int i = 0; i < bk128_pkg::BLOCK_W; i++) begin
      perm[bk128_pkg::PERM[i]] = sub[i];
    end
    rkey = {d_in.key[0], d_in.key[bk128_pkg::BLOCK_W-1:1]};
    rk = rkey;
    rcon = bk128_pkg::RCON[round_idx];
    if (use_rc) begin
      for (int j = 0; j < bk128_pkg::NUM_RC_BITS; j++) begin
        rk[bk128_pkg::RC_POS[j]] = rk[bk128_pkg::RC_POS[j]] ^ rcon[j];
      end
    end
    cell_nxt = d_in;
    if (d_in.left != '0) begin
      cell_nxt.state = perm ^ rk;
      cell_nxt.key = rkey;
      cell_nxt.left = d_in.left - bk128_pkg::ROUND_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else begin
      cell_r.valid <= cell_nxt.valid;
    end
    cell_r.left <= cell_nxt.left;
    cell_r.key <= cell_nxt.key;
    cell_r.state <= cell_nxt.state;
  end

  assign d_out = cell_r;

endmodule
